### hw/rtl/orsr_pkg.sv
// Shared types and constants for the overwrite ring sample recorder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package orsr_pkg;

  localparam int MAX_DEPTH_DEFAULT   = 256;
  localparam int SAMPLE_BITS_DEFAULT = 32;
  localparam int CAP_RESET           = 256;
  localparam int CNT_W               = 9;
  localparam int PADDR_W             = 3;

  localparam logic [0:0] REG_RING_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_END    = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] start_time;
    logic [31:0] sample_data;
    logic [7:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic             read_valid;
    logic [CNT_W-1:0] fill_count;
    logic             overflow_seen;
    logic             recording;
    logic [31:0]      appended_total;
    logic [31:0]      run_start;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] value;
  } cfg_wr_t;

endpackage

`default_nettype wire

### hw/rtl/orsr_store.sv
// Sample memory of the recorder: one port, synchronous write, registered read.
// Uses orsr_pkg for the command struct.
`default_nettype none

module orsr_store #(
  parameter int DEPTH  = orsr_pkg::MAX_DEPTH_DEFAULT,
  parameter int DATA_W = orsr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire                       clk,
  input  orsr_pkg::mem_cmd_t        cmd,
  input  wire  [$clog2(DEPTH)-1:0]  addr,
  input  wire  [DATA_W-1:0]         wdata,
  output logic [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  // The read register holds its value until the next read, so a stalled
  // result keeps its data while later appends write the array.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/orsr_ctrl.sv
// Control state, address generation and result register of the recorder.
// Uses orsr_pkg; drives the command and address of orsr_store.
`default_nettype none

module orsr_ctrl #(
  parameter int MAX_DEPTH   = orsr_pkg::MAX_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = orsr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  orsr_pkg::cfg_wr_t                  cfg_wr,
  output logic [orsr_pkg::CNT_W-1:0]         capacity,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  orsr_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output orsr_pkg::out_item_t                out_data,
  output orsr_pkg::mem_cmd_t                 mem_cmd,
  output logic [$clog2(MAX_DEPTH)-1:0]       mem_addr,
  output logic [SAMPLE_BITS-1:0]             mem_wdata,
  input  wire  [SAMPLE_BITS-1:0]             mem_rdata
);

  localparam int CW     = orsr_pkg::CNT_W;
  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam logic [CW-1:0] CAP_INIT = (orsr_pkg::CAP_RESET > MAX_DEPTH) ?
                                       CW'(MAX_DEPTH) : CW'(orsr_pkg::CAP_RESET);
  localparam logic [CW-1:0] CAP_MAX  = (MAX_DEPTH > 511) ? 9'd511 : CW'(MAX_DEPTH);

  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [31:0]   total_r, total_nxt;
  logic          ovf_r, ovf_nxt;
  logic          run_r, run_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          rvalid_r, rvalid_nxt;

  logic          in_fire;
  logic [CW-1:0] wp_inc;
  logic [CW-1:0] cfg_val;
  logic [CW-1:0] base;
  logic [CW:0]   pos_sum;
  logic [CW:0]   pos;
  logic          idx_ok;
  logic [63:0]   rd_wide;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign capacity = cap_r;

  assign wp_inc  = wp_r + 1'b1;
  assign idx_ok  = {1'b0, in_data.read_index} < held_r;
  assign base    = (held_r < cap_r) ? '0 : wp_r;
  assign pos_sum = {1'b0, base} + {2'b0, in_data.read_index};
  assign pos     = (pos_sum >= {1'b0, cap_r}) ? (pos_sum - {1'b0, cap_r}) : pos_sum;

  always_comb begin
    cfg_val = cfg_wr.value;
    if (cfg_val == '0) begin
      cfg_val = CW'(1);
    end
    if (32'(cfg_wr.value) > MAX_DEPTH) begin
      cfg_val = CAP_MAX;
    end
  end

  always_comb begin
    cap_nxt       = cap_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    run_nxt       = run_r;
    stamp_nxt     = stamp_r;
    rvalid_nxt    = rvalid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_cmd       = '0;
    mem_addr      = ADDR_W'(pos);
    mem_wdata     = SAMPLE_BITS'(in_data.sample_data);

    if (cfg_wr.en) begin
      cap_nxt  = cfg_val;
      wp_nxt   = '0;
      held_nxt = '0;
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      rvalid_nxt    = 1'b0;
      unique case (in_data.mode)
        orsr_pkg::MODE_BEGIN: begin
          stamp_nxt = in_data.start_time;
          run_nxt   = 1'b1;
          wp_nxt    = '0;
          held_nxt  = '0;
          total_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        orsr_pkg::MODE_END: begin
          run_nxt = 1'b0;
        end
        orsr_pkg::MODE_APPEND: begin
          if (run_r) begin
            mem_cmd.wr = 1'b1;
            mem_addr   = ADDR_W'(wp_r);
            wp_nxt     = (wp_inc >= cap_r) ? '0 : wp_inc;
            total_nxt  = total_r + 32'd1;
            if (held_r < cap_r) begin
              held_nxt = held_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        orsr_pkg::MODE_READ: begin
          rvalid_nxt = idx_ok;
          mem_cmd.rd = idx_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_INIT;
      wp_r        <= '0;
      held_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      run_r       <= 1'b0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      run_r       <= run_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= rvalid_nxt;
    end
  end

  // The result fields after the read are the live state: it changes on acceptance,
  // which also replaces the pending result, and on a capacity write.
  assign rd_wide   = 64'(mem_rdata);
  assign out_valid = out_valid_r;

  always_comb begin
    out_data                = '0;
    out_data.read_data      = rvalid_r ? rd_wide[31:0] : 32'd0;
    out_data.read_valid     = rvalid_r;
    out_data.fill_count     = held_r;
    out_data.overflow_seen  = ovf_r;
    out_data.recording      = run_r;
    out_data.appended_total = total_r;
    out_data.run_start      = stamp_r;
  end

  a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r)
    else $error("fill count exceeds ring capacity");

  a_wp_lt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < cap_r)
    else $error("write pointer outside ring");

  a_full_append_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_wr.en && in_data.mode == orsr_pkg::MODE_APPEND && run_r &&
     held_r == cap_r) |=> ovf_r)
    else $error("append to a full ring did not set overflow");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.wr |-> !mem_cmd.rd)
    else $error("memory read and write in the same cycle");

endmodule

`default_nettype wire

### hw/rtl/overwrite_ring_sample_recorder.sv
// Overwrite ring sample recorder: accepts one transaction per clock unless stalled
// and returns one result per transaction. Each item does at most one access of the
// sample memory (a write for append, a read for read sample), and that one memory
// port sets the rate of one item per cycle. The memory is not cleared after reset;
// an unwritten slot reads as undefined data. The ring capacity register is to be
// written through the APB port while the block is idle (not enforced); a write also
// empties the ring. Depends on orsr_pkg, orsr_ctrl and orsr_store.
`default_nettype none

module overwrite_ring_sample_recorder #(
  parameter int MAX_DEPTH   = orsr_pkg::MAX_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = orsr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [orsr_pkg::PADDR_W-1:0]     paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  orsr_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output orsr_pkg::out_item_t              out_data
);

  localparam int ADDR_W = $clog2(MAX_DEPTH);

  orsr_pkg::cfg_wr_t             cfg_wr;
  orsr_pkg::mem_cmd_t            mem_cmd;
  logic [orsr_pkg::CNT_W-1:0]    capacity;
  logic [ADDR_W-1:0]             mem_addr;
  logic [SAMPLE_BITS-1:0]        mem_wdata;
  logic [SAMPLE_BITS-1:0]        mem_rdata;
  logic                          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[orsr_pkg::PADDR_W-1] == orsr_pkg::REG_RING_CAPACITY;

  assign cfg_wr.en    = psel && penable && pwrite && pready && reg_sel;
  assign cfg_wr.value = pwdata[orsr_pkg::CNT_W-1:0];

  assign prdata = reg_sel ? 32'(capacity) : 32'd0;

  orsr_ctrl #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  orsr_store #(
    .DEPTH  (MAX_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
